>>> design/itda_pkg.sv
// shared types and constants for the integer to decimal ascii converter
package itda_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 6;
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int POS_W      = 4;
  localparam int BIT_CNT_W  = 5;

  localparam logic [CHAR_W-1:0] CODE_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CODE_ZERO  = 6'd48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic start_emit;
    logic push_sign;
    logic push_digit;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic negative;
    logic pos_zero;
    logic can_push;
  } status_t;

endpackage

>>> design/itda_datapath.sv
// datapath: magnitude, shift-add-3 bcd conversion, digit select and output register
module itda_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  itda_pkg::cmd_t                   cmd,
  output itda_pkg::status_t                status,
  input  logic [itda_pkg::VALUE_W-1:0]     value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [itda_pkg::CHAR_W-1:0]      out_char,
  output logic                             out_last
);

  logic [itda_pkg::VALUE_W-1:0]   bin_r, bin_nxt;
  logic [itda_pkg::BCD_W-1:0]     bcd_r, bcd_nxt;
  logic                           neg_r;
  logic [itda_pkg::BIT_CNT_W-1:0] bitcnt_r;
  logic [itda_pkg::POS_W-1:0]     pos_r;
  logic [itda_pkg::POS_W-1:0]     msd;
  logic [itda_pkg::BCD_W-1:0]     bcd_adj;
  logic [itda_pkg::DIGIT_W-1:0]   digit;
  logic                           out_valid_r;
  logic [itda_pkg::CHAR_W-1:0]    out_char_r;
  logic                           out_last_r;
  logic                           can_push;

  // add 3 to every digit of 5 or more, then shift one bit in
  always_comb begin
    logic [itda_pkg::DIGIT_W-1:0] nib;
    for (int i = 0; i < itda_pkg::NUM_DIGITS; i++) begin
      nib = bcd_r[i*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W];
      bcd_adj[i*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W] =
        (nib >= 4'd5) ? nib + 4'd3 : nib;
    end
    {bcd_nxt, bin_nxt} = {bcd_adj[itda_pkg::BCD_W-2:0], bin_r, 1'b0};
  end

  // position of the most significant nonzero digit
  always_comb begin
    msd = '0;
    for (int i = 0; i < itda_pkg::NUM_DIGITS; i++) begin
      if (bcd_r[i*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W] != '0) begin
        msd = itda_pkg::POS_W'(i);
      end
    end
  end

  assign digit    = bcd_r[pos_r*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W];
  assign can_push = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= value[itda_pkg::VALUE_W-1];
      bin_r <= value[itda_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
      bcd_r <= '0;
    end else if (cmd.shift) begin
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitcnt_r <= '0;
      pos_r    <= '0;
    end else begin
      if (cmd.load) begin
        bitcnt_r <= '0;
      end else if (cmd.shift) begin
        bitcnt_r <= bitcnt_r + 1'b1;
      end
      if (cmd.start_emit) begin
        pos_r <= msd;
      end else if (cmd.push_digit) begin
        pos_r <= pos_r - 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push_sign || cmd.push_digit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_sign) begin
      out_char_r <= itda_pkg::CODE_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.push_digit) begin
      out_char_r <= itda_pkg::CODE_ZERO + {2'b00, digit};
      out_last_r <= (pos_r == '0);
    end
  end

  assign status.conv_done = (bitcnt_r == itda_pkg::BIT_CNT_W'(itda_pkg::VALUE_W - 1));
  assign status.negative  = neg_r;
  assign status.pos_zero  = (pos_r == '0);
  assign status.can_push  = can_push;

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

>>> design/itda_controller.sv
// controller: sequences load, conversion, sign and digit emission
module itda_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  itda_pkg::status_t status,
  output itda_pkg::cmd_t    cmd
);

  itda_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itda_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      itda_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = itda_pkg::ST_CONVERT;
      end
      itda_pkg::ST_CONVERT: begin
        if (status.conv_done) state_nxt = itda_pkg::ST_SIGN;
      end
      itda_pkg::ST_SIGN: begin
        if (status.can_push) state_nxt = itda_pkg::ST_DIGITS;
      end
      itda_pkg::ST_DIGITS: begin
        if (status.can_push && status.pos_zero) state_nxt = itda_pkg::ST_IDLE;
      end
      default: state_nxt = itda_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      itda_pkg::ST_IDLE: begin
        in_ready = rst_n;
        cmd.load = in_valid && rst_n;
      end
      itda_pkg::ST_CONVERT: begin
        cmd.shift = 1'b1;
      end
      itda_pkg::ST_SIGN: begin
        cmd.start_emit = status.can_push;
        cmd.push_sign  = status.can_push && status.negative;
      end
      itda_pkg::ST_DIGITS: begin
        cmd.push_digit = status.can_push;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> design/int_to_decimal_ascii_core.sv
// top level of the signed 32-bit integer to decimal ascii converter
//
// input stream: one signed 32-bit integer per transaction on in_tdata
// output stream: one ascii character per transaction, most significant first,
//   a leading '-' for negative values, no leading zeros; out_tlast marks the
//   final character of each number
// conversion: after an input transaction the magnitude is converted to bcd by a
//   shift-add-3 loop, one bit per cycle; the sign state then finds the leading
//   digit and emits the '-' of a negative value; then one digit per cycle while
//   the receiver does not stall; a number has 1 to 10 digits
// the next number is taken once the last character sits in the output
//   register, so it overlaps with that character waiting for the receiver
// receiver stall: the output register holds its character and the
//   controller waits; nothing is dropped
// reset: clears the controller, the output valid and the bit and digit counters;
//   in_tready is held low during reset and rises as soon as reset is released
module int_to_decimal_ascii_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [5:0] char_code, [7:6] zero
  output logic        out_tlast   // is_last
);

  itda_pkg::cmd_t                  cmd;
  itda_pkg::status_t               status;
  logic [itda_pkg::CHAR_W-1:0]     out_char;

  itda_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  itda_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .value     (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_char),
    .out_last  (out_tlast)
  );

  assign out_tdata = {2'b00, out_char};

endmodule

>>> design/itda_checker.sv
// port-level checker for the converter, bound to the top level
module itda_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [31:0] in_tdata,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  logic unused_data;
  assign unused_data = ^in_tdata;

  // stalled output keeps its transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output transaction changed while stalled");

  // busy right after taking a number
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an input transaction");

  // no new number while a text is still incomplete
  a_no_accept_mid_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready in the middle of a number");

  // only '-' or a digit, and '-' never ends a text
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata == 8'd45 && !out_tlast) ||
                   (out_tdata >= 8'd48 && out_tdata <= 8'd57))
    else $error("illegal output character");

endmodule

bind int_to_decimal_ascii_core itda_checker u_itda_checker (.*);

>>> tb/sv/tb_int_to_decimal_ascii_core.sv
// testbench for int_to_decimal_ascii_core: directed and random integers with character checks
`timescale 1ns / 100ps

module tb_int_to_decimal_ascii_core;

  localparam int STALL_LIMIT    = 5000;
  localparam int ITEMS_PER_PHASE = 28;
  localparam int NUM_PHASES     = 4;
  localparam int NUM_DIRECTED   = 20;
  localparam int DRAIN_CYCLES   = 60;

  typedef struct {
    logic [itda_pkg::CHAR_W-1:0] code;
    logic                        last;
  } char_t;

  typedef struct {
    logic [itda_pkg::VALUE_W-1:0] value;
    string                        text;
  } directed_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  char_t         pending_chars[$];
  char_t         want_char;
  directed_row_t directed_rows [NUM_DIRECTED];
  int            fail_count;
  int            idle_cycles;
  int            in_idle_pct;
  int            out_stall_pct;
  int            phase_in_idle [NUM_PHASES]  = '{0, 73, 0, 36};
  int            phase_out_stall [NUM_PHASES] = '{0, 0, 73, 36};

  int_to_decimal_ascii_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // decimal text of a signed integer, most significant character first
  function automatic void predict_decimal_text(input logic [itda_pkg::VALUE_W-1:0] value);
    logic                         negative;
    logic [itda_pkg::VALUE_W-1:0] mag;
    logic [itda_pkg::DIGIT_W-1:0] digits [0:10];
    int                           ndig;
    negative = value[itda_pkg::VALUE_W-1];
    mag = negative ? (~value + 32'd1) : value;
    ndig = 0;
    do begin
      digits[ndig] = itda_pkg::DIGIT_W'(mag % 32'd10);
      ndig++;
      mag = mag / 32'd10;
    end while (mag != 0);
    if (negative) begin
      pending_chars.push_back('{code: itda_pkg::CODE_MINUS, last: 1'b0});
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      pending_chars.push_back('{code: itda_pkg::CODE_ZERO + itda_pkg::CHAR_W'(digits[i]),
                                last: (i == 0)});
    end
  endfunction

  function automatic void push_known_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      pending_chars.push_back('{code: itda_pkg::CHAR_W'(text[i]),
                                last: (i == text.len() - 1)});
    end
  endfunction

  function automatic logic [itda_pkg::VALUE_W-1:0] random_value();
    logic [63:0]                  span;
    logic [itda_pkg::VALUE_W-1:0] v;
    int                           k;
    span = 64'd1;
    case ($urandom_range(3))
      0: v = $urandom;
      1: begin
        k = $urandom_range(1, 9);
        repeat (k) span = span * 64'd10;
        v = itda_pkg::VALUE_W'(span) + itda_pkg::VALUE_W'($urandom_range(2)) - 32'd1;
        if ($urandom_range(1)) v = ~v + 32'd1;
      end
      2: begin
        k = $urandom_range(1, 10);
        repeat (k) span = span * 64'd10;
        v = itda_pkg::VALUE_W'({32'd0, $urandom} % span);
        if ($urandom_range(1)) v = ~v + 32'd1;
      end
      default: v = itda_pkg::VALUE_W'($urandom_range(40)) - 32'd20;
    endcase
    return v;
  endfunction

  // drive one integer, hold it until taken, then queue its characters
  task automatic send_value(input logic [itda_pkg::VALUE_W-1:0] value, input string text);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (text.len() > 0) push_known_text(text);
    else predict_decimal_text(value);
    @(negedge clk);
  endtask

  task automatic wait_all_chars();
    while (pending_chars.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected character", out_tdata, 0);
      end else begin
        want_char = pending_chars.pop_front();
        if (out_tdata !== {2'b00, want_char.code})
          report_mismatch("char_code", out_tdata, want_char.code);
        if (out_tlast !== want_char.last)
          report_mismatch("is_last", out_tlast, want_char.last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles with no transaction", idle_cycles);
      $display("tb_int_to_decimal_ascii_core NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    fail_count    = 0;
    idle_cycles   = 0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    directed_rows = '{
      '{32'd0,          "0"},
      '{32'd1,          "1"},
      '{32'hFFFFFFFF,   "-1"},
      '{32'h7FFFFFFF,   "2147483647"},
      '{32'h80000000,   "-2147483648"},
      '{32'h80000001,   "-2147483647"},
      '{32'd9,          "9"},
      '{32'd10,         "10"},
      '{-32'sd9,        ""},
      '{-32'sd10,       "-10"},
      '{32'd99,         ""},
      '{32'd100,        ""},
      '{32'd999999999,  ""},
      '{32'd1000000000, "1000000000"},
      '{-32'sd1000000000, ""},
      '{32'd12345,      ""},
      '{-32'sd54321,    ""},
      '{32'hAAAAAAAA,   ""},
      '{32'h55555555,   ""},
      '{32'hFFFFFFFE,   "-2"}
    };
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) send_value(directed_rows[i].value, directed_rows[i].text);

    for (int p = 0; p < NUM_PHASES; p++) begin
      in_tvalid <= 1'b0;
      wait_all_chars();
      in_idle_pct   = phase_in_idle[p];
      out_stall_pct = phase_out_stall[p];
      repeat (ITEMS_PER_PHASE) send_value(random_value(), "");
    end

    in_tvalid <= 1'b0;
    wait_all_chars();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_int_to_decimal_ascii_core OK");
    end else begin
      $display("tb_int_to_decimal_ascii_core NOT OK");
    end
    $finish;
  end

endmodule
